// ===== sv/sdl_pkg.sv =====
// sdl_pkg: shared types, constants and helpers of the stereo feedback delay
// holds the sample arithmetic helpers, the mode codes, the lane control bundle
// and the saturator curve table built at elaboration; depends on nothing
package sdl_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int ACC_W       = 48;
	localparam int GAIN_W      = 17;
	localparam int DRIVE_W     = GAIN_W + 1;
	localparam int FR_W        = 8;
	localparam int DEPTH_DEF   = 65536;

	// saturator curve: power of two entries plus one end point
	localparam int TANH_BITS = 8;
	localparam int TANH_SIZE = 1 << TANH_BITS;
	localparam int TANH_SH   = FRAC_BITS + 2 - TANH_BITS;

	localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);
	localparam logic signed [15:0] SMOOTH_COEF = 16'sd13107;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [1:0] {
		MODE_STEREO = 2'd0,
		MODE_PING   = 2'd1,
		MODE_MONO   = 2'd2,
		MODE_TAPE   = 2'd3
	} mode_t;

	// per-step enables and operands the sequencer hands to both lanes
	typedef struct packed {
		logic                rd_en;
		logic                ok0;
		logic                ok1;
		logic                lat0;
		logic                interp;
		logic [FR_W-1:0]     frac;
		logic                merge;
		logic                smooth;
		logic                tape;
		logic                absm;
		logic                tanh_en;
		logic                scale;
		logic                wr_en;
		logic [GAIN_W-1:0]   fg;
		logic [GAIN_W-1:0]   dry;
		logic [GAIN_W-1:0]   wet;
		logic [DRIVE_W-1:0]  drive;
	} lane_ctrl_t;

	localparam acc_t SMAX = acc_t'((longint'(1) << FRAC_BITS) - 1);
	localparam acc_t SMIN = acc_t'(-(longint'(1) << FRAC_BITS));

	function automatic sample_t sat_s(input acc_t v);
		sample_t r;
		if (v > SMAX) begin
			r = SMAX[SAMPLE_BITS-1:0];
		end else if (v < SMIN) begin
			r = SMIN[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	// round half up at 16 fraction bits
	function automatic acc_t rnd16(input acc_t v);
		return (v + acc_t'(32768)) >>> 16;
	endfunction

	function automatic logic [GAIN_W-1:0] clamp_unity(input logic [GAIN_W-1:0] v);
		return (v > UNITY) ? UNITY : v;
	endfunction

	typedef logic signed [SAMPLE_BITS:0] tanh_ent_t;
	typedef tanh_ent_t tanh_tab_t [0:TANH_SIZE];

	localparam logic [63:0] EXP_Q16 [0:8] = '{
		64'd65536, 64'd178145, 64'd484249, 64'd1316326, 64'd3578144,
		64'd9726405, 64'd26439109, 64'd71868951, 64'd195360063
	};

	// shift and subtract quotient, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q, rem;
		q = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], a[i]};
			if (rem >= b) begin
				rem = rem - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(4k/size) = 1 - 2/(exp(8k/size) + 1), exp from whole powers and a series
	function automatic tanh_tab_t build_tanh();
		tanh_tab_t t;
		logic [63:0] y8, whole, f, term, sum, e24, den, num, ent;
		for (int k = 0; k <= TANH_SIZE; k++) begin
			y8 = 64'(k) * 64'd8;
			whole = y8 >> TANH_BITS;
			f = ((y8 & 64'(TANH_SIZE - 1)) << 32) >> TANH_BITS;
			term = 64'd1 << 32;
			sum = term;
			for (int n = 1; n <= 24; n++) begin
				term = udiv64((term * f) >> 32, 64'(n));
				sum = sum + term;
			end
			if (whole > 64'd8) begin
				whole = 64'd8;
			end
			e24 = ((sum >> 8) * EXP_Q16[whole[3:0]]) >> 16;
			den = e24 + (64'd1 << 24);
			num = 64'd1 << (FRAC_BITS + 25);
			ent = (64'd1 << FRAC_BITS) - udiv64(num + (den >> 1), den);
			t[k] = tanh_ent_t'(ent[SAMPLE_BITS:0]);
		end
		return t;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

// ===== sv/sdl_merge.sv =====
// sdl_merge: combines the two lanes' delayed reads into write and wet values
// per mode (stereo and tape, ping-pong cross feed, mono sum); uses sdl_pkg
module sdl_merge (
	input  sdl_pkg::mode_t   mode,
	input  sdl_pkg::sample_t in_l,
	input  sdl_pkg::sample_t in_r,
	input  sdl_pkg::sample_t fb_l,
	input  sdl_pkg::sample_t fb_r,
	input  sdl_pkg::sample_t c,
	output sdl_pkg::sample_t w_l,
	output sdl_pkg::sample_t w_r,
	output sdl_pkg::sample_t wet_l,
	output sdl_pkg::sample_t wet_r
);

	sdl_pkg::sample_t lc;
	sdl_pkg::acc_t    sf;
	sdl_pkg::acc_t    sh;

	always_comb begin
		w_l   = sdl_pkg::sat_s(sdl_pkg::acc_t'(in_l) + sdl_pkg::acc_t'(fb_l));
		w_r   = sdl_pkg::sat_s(sdl_pkg::acc_t'(in_r) + sdl_pkg::acc_t'(fb_r));
		wet_l = fb_l;
		wet_r = fb_r;
		lc    = sdl_pkg::sat_s(sdl_pkg::acc_t'(in_l) + sdl_pkg::acc_t'(c));
		// halvings floor
		sf    = (sdl_pkg::acc_t'(fb_l) + sdl_pkg::acc_t'(fb_r)) >>> 1;
		sh    = (sdl_pkg::acc_t'(in_l) + sdl_pkg::acc_t'(in_r)) >>> 1;
		unique case (mode) inside
			sdl_pkg::MODE_PING: begin
				w_l = sdl_pkg::sat_s(sdl_pkg::acc_t'(lc) + sdl_pkg::acc_t'(fb_r));
				w_r = sdl_pkg::sat_s(sdl_pkg::acc_t'(c) + sdl_pkg::acc_t'(fb_l));
			end
			sdl_pkg::MODE_MONO: begin
				w_l   = sdl_pkg::sat_s(sh + sf);
				w_r   = sdl_pkg::sat_s(sh + sf);
				wet_l = sf[sdl_pkg::SAMPLE_BITS-1:0];
				wet_r = sf[sdl_pkg::SAMPLE_BITS-1:0];
			end
			sdl_pkg::MODE_STEREO, sdl_pkg::MODE_TAPE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/sdl_lane.sv =====
// sdl_lane: one channel of the delay: delay store, interpolated read, tape
// smoother and saturator, feedback scaling and dry/wet mix; uses sdl_pkg
module sdl_lane #(
	parameter int STORE_DEPTH = sdl_pkg::DEPTH_DEF,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdl_pkg::lane_ctrl_t ctrl,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  sdl_pkg::sample_t    in_s,
	input  sdl_pkg::sample_t    w_in,
	input  sdl_pkg::sample_t    wet_in,
	output sdl_pkg::sample_t    fb,
	output sdl_pkg::sample_t    res
);

	localparam int SB     = sdl_pkg::SAMPLE_BITS;
	localparam int AQ_W   = SB + sdl_pkg::DRIVE_W;
	localparam int IDX_LO = sdl_pkg::TANH_SH + 16;
	localparam int TB     = sdl_pkg::TANH_BITS;

	sdl_pkg::sample_t mem [0:STORE_DEPTH-1];

	sdl_pkg::sample_t rd_q, d0_q, fb_q, w_q, wet_q, res_q, smooth_q, t_q, wd_q;
	sdl_pkg::acc_t    pd_q;
	logic [AQ_W-1:0]  a_q;

	sdl_pkg::sample_t d1, s_new, t_n, wd_n, res_n, src;
	logic signed [9:0] wa, wb;
	logic signed [sdl_pkg::GAIN_W:0] fg_s, dry_s, wet_s;
	logic signed [16:0] tfr_s;
	sdl_pkg::acc_t ip0, ip1, isum, ish, op, sd, sm, tdiff, tp, r, sp, pd_n;
	logic [SB-1:0]    mag;
	logic [AQ_W-1:0]  a_n;
	logic             over;
	logic [TB-1:0]    idx;
	logic [TB:0]      idx_hi;
	logic [15:0]      tfr;

	// store: one read and one write port, registered read data
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wd_q;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		fg_s  = {1'b0, ctrl.fg};
		dry_s = {1'b0, ctrl.dry};
		wet_s = {1'b0, ctrl.wet};

		// linear interpolation between the two neighbors
		d1   = ctrl.ok1 ? rd_q : '0;
		wa   = {1'b0, 9'd256 - {1'b0, ctrl.frac}};
		wb   = {2'b00, ctrl.frac};
		ip0  = d0_q * wa;
		ip1  = d1 * wb;
		isum = ip0 + ip1 + sdl_pkg::acc_t'(128);
		ish  = isum >>> 8;

		// dry product first, wet product added a step later
		pd_n  = in_s * dry_s;
		op    = wet_q * wet_s;
		res_n = sdl_pkg::sat_s(sdl_pkg::rnd16(pd_q + op));

		// one-pole smoother
		sd    = sdl_pkg::acc_t'(w_q) - sdl_pkg::acc_t'(smooth_q);
		sm    = sd * sdl_pkg::SMOOTH_COEF;
		s_new = sdl_pkg::sat_s(sdl_pkg::acc_t'(smooth_q) + sdl_pkg::rnd16(sm));

		// saturator argument magnitude times drive
		mag = smooth_q[SB-1] ? SB'(-smooth_q) : SB'(smooth_q);
		a_n = AQ_W'(mag) * AQ_W'(ctrl.drive);

		// curve lookup with interpolation, end point beyond the table
		over   = |a_q[AQ_W-1:IDX_LO+TB];
		idx    = a_q[IDX_LO+TB-1:IDX_LO];
		idx_hi = {1'b0, idx} + (TB+1)'(1);
		tfr    = a_q[IDX_LO-1:sdl_pkg::TANH_SH];
		tfr_s  = {1'b0, tfr};
		tdiff  = sdl_pkg::acc_t'(sdl_pkg::TANH_TAB[idx_hi])
			- sdl_pkg::acc_t'(sdl_pkg::TANH_TAB[idx]);
		tp     = tdiff * tfr_s;
		r      = over ? sdl_pkg::acc_t'(sdl_pkg::TANH_TAB[sdl_pkg::TANH_SIZE])
			: sdl_pkg::acc_t'(sdl_pkg::TANH_TAB[idx]) + sdl_pkg::rnd16(tp);
		t_n    = sdl_pkg::sat_s(smooth_q[SB-1] ? -r : r);

		// feedback scaling of the value to store
		src  = ctrl.tape ? t_q : w_q;
		sp   = src * fg_s;
		wd_n = sdl_pkg::sat_s(sdl_pkg::rnd16(sp));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (ctrl.smooth && ctrl.tape) begin
			smooth_q <= s_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.lat0) begin
			d0_q <= ctrl.ok0 ? rd_q : '0;
		end
		if (ctrl.interp) begin
			fb_q <= ish[SB-1:0];
		end
		if (ctrl.merge) begin
			w_q   <= w_in;
			wet_q <= wet_in;
			pd_q  <= pd_n;
		end
		if (ctrl.smooth) begin
			res_q <= res_n;
		end
		if (ctrl.absm) begin
			a_q <= a_n;
		end
		if (ctrl.tanh_en) begin
			t_q <= t_n;
		end
		if (ctrl.scale) begin
			wd_q <= wd_n;
		end
	end

	assign fb  = fb_q;
	assign res = res_q;

endmodule

// ===== sv/stereo_feedback_delay.sv =====
// stereo_feedback_delay: top level, register port, item sequencer, two lanes
// and the cross-lane merge; uses sdl_pkg, sdl_lane and sdl_merge
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in       | sink      | in_valid / in_stall  | in_left, in_right (Q1.23)
//  out      | source    | out_valid / out_stall| out_left, out_right (Q1.23)
//  config   | APB slave | psel/penable/pready  | paddr, pwdata, prdata
//
// an item is accepted only while the sequencer is idle, so the next item waits
// until the result of the last one is registered: the sequencer walks two reads
// of each lane's store (one read and one write port), the interpolation, merge,
// smoother, drive, curve and scaling steps
// in_stall is high whenever an item is in flight; a finished item waits in its
// last step while the output register still holds an unaccepted result, and
// its store write and pointer step wait with it
// reset clears the control state; the write pointer and a wrap flag tell which
// store entries were ever written, so never written entries read as zero with
// no clearing pass
module stereo_feedback_delay #(
	parameter int STORE_DEPTH = sdl_pkg::DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sdl_pkg::sample_t     in_left,
	input  sdl_pkg::sample_t     in_right,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sdl_pkg::sample_t     out_left,
	output sdl_pkg::sample_t     out_right,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int GW = sdl_pkg::GAIN_W;
	localparam int XW = ((AW + 8 > 24) ? AW + 8 : 24) + 1;
	localparam int RW = AW + 9;
	localparam longint DMAX = longint'(STORE_DEPTH - 2) * 256;
	localparam longint WRAP = longint'(STORE_DEPTH) * 256;

	// register indexes
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_DELAY = 3'd1;
	localparam logic [2:0] REG_FB    = 3'd2;
	localparam logic [2:0] REG_DEPTH = 3'd3;
	localparam logic [2:0] REG_MIX   = 3'd4;
	localparam logic [2:0] REG_FLOOR = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE, S_RA0, S_RA1, S_INTP, S_MRG, S_SMTH, S_ABS, S_TANH, S_SCALE, S_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	sdl_pkg::mode_t  mode_q;
	logic [23:0]     delay_q;
	logic [GW-1:0]   fbg_q, depth_q, mix_q, floor_q;

	logic [AW-1:0]   wp_q, i0_q, i1_q;
	logic            full_q, ok0_q, ok1_q;
	logic [7:0]      fr_q;
	sdl_pkg::sample_t in_left_q, in_right_q, c_q, out_left_q, out_right_q;
	logic            out_valid_q;

	logic            cfg_wr, accept, fin_go, pass_dry;
	logic [XW-1:0]   dx, dcl_x;
	logic [RW-1:0]   rp, rp_w;
	logic [AW-1:0]   i0_n, i1_n;
	logic [GW-1:0]   mix_c, dinv;
	logic [GW:0]     dry2, wet2;
	logic signed [GW:0] dinv_s;
	sdl_pkg::acc_t   cp;
	sdl_pkg::lane_ctrl_t ctrl;
	sdl_pkg::sample_t fb_l, fb_r, w_l, w_r, wet_l, wet_r, res_l, res_r;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sdl_pkg::MODE_STEREO;
			delay_q <= 24'd256;
			fbg_q   <= '0;
			depth_q <= '0;
			mix_q   <= '0;
			floor_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_MODE:  mode_q  <= sdl_pkg::mode_t'(pwdata[1:0]);
				REG_DELAY: delay_q <= pwdata[23:0];
				REG_FB:    fbg_q   <= pwdata[GW-1:0];
				REG_DEPTH: depth_q <= pwdata[GW-1:0];
				REG_MIX:   mix_q   <= pwdata[GW-1:0];
				REG_FLOOR: floor_q <= pwdata[GW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_MODE:  prdata = 32'(mode_q);
			REG_DELAY: prdata = 32'(delay_q);
			REG_FB:    prdata = 32'(fbg_q);
			REG_DEPTH: prdata = 32'(depth_q);
			REG_MIX:   prdata = 32'(mix_q);
			REG_FLOOR: prdata = 32'(floor_q);
			default:   prdata = '0;
		endcase
	end

	// read position: clamped delay behind the write pointer, wrapped
	always_comb begin
		dx = XW'(delay_q);
		if (dx < XW'(256)) begin
			dcl_x = XW'(256);
		end else if (dx > XW'(DMAX)) begin
			dcl_x = XW'(DMAX);
		end else begin
			dcl_x = dx;
		end
		rp   = {1'b0, wp_q, 8'd0} - {1'b0, dcl_x[AW+7:0]};
		rp_w = rp[RW-1] ? rp + RW'(WRAP) : rp;
		i0_n = rp_w[AW+7:8];
		i1_n = (i0_n == AW'(STORE_DEPTH - 1)) ? '0 : i0_n + AW'(1);
	end

	// gains
	always_comb begin
		mix_c    = sdl_pkg::clamp_unity(mix_q);
		dinv     = sdl_pkg::UNITY - sdl_pkg::clamp_unity(depth_q);
		dinv_s   = {1'b0, dinv};
		dry2     = {sdl_pkg::UNITY - mix_c, 1'b0};
		wet2     = {mix_c, 1'b0};
		pass_dry = (mix_c <= floor_q);
		cp       = in_right_q * dinv_s;
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// step enables for both lanes
	always_comb begin
		ctrl       = '0;
		ctrl.ok0   = ok0_q;
		ctrl.ok1   = ok1_q;
		ctrl.frac  = fr_q;
		ctrl.tape  = (mode_q == sdl_pkg::MODE_TAPE);
		ctrl.fg    = sdl_pkg::clamp_unity(fbg_q);
		ctrl.dry   = (dry2 > (GW+1)'(sdl_pkg::UNITY)) ? sdl_pkg::UNITY : dry2[GW-1:0];
		ctrl.wet   = (wet2 > (GW+1)'(sdl_pkg::UNITY)) ? sdl_pkg::UNITY : wet2[GW-1:0];
		ctrl.drive = (GW+1)'(sdl_pkg::UNITY) + {sdl_pkg::clamp_unity(depth_q), 1'b0};
		unique case (state_q)
			S_RA0:   ctrl.rd_en = 1'b1;
			S_RA1: begin
				ctrl.rd_en = 1'b1;
				ctrl.lat0  = 1'b1;
			end
			S_INTP:  ctrl.interp  = 1'b1;
			S_MRG:   ctrl.merge   = 1'b1;
			S_SMTH:  ctrl.smooth  = 1'b1;
			S_ABS:   ctrl.absm    = 1'b1;
			S_TANH:  ctrl.tanh_en = 1'b1;
			S_SCALE: ctrl.scale   = 1'b1;
			S_FIN:   ctrl.wr_en   = fin_go;
			default: begin
			end
		endcase
	end

	// sequencer, write pointer, fill tracking and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_left_q  <= '0;
			out_right_q <= '0;
			wp_q        <= '0;
			full_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (accept) state_q <= S_RA0;
				S_RA0:   state_q <= S_RA1;
				S_RA1:   state_q <= S_INTP;
				S_INTP:  state_q <= S_MRG;
				S_MRG:   state_q <= S_SMTH;
				S_SMTH:  state_q <= S_ABS;
				S_ABS:   state_q <= S_TANH;
				S_TANH:  state_q <= S_SCALE;
				S_SCALE: state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						out_left_q  <= pass_dry ? in_left_q : res_l;
						out_right_q <= pass_dry ? in_right_q : res_r;
						if (wp_q == AW'(STORE_DEPTH - 1)) begin
							wp_q   <= '0;
							full_q <= 1'b1;
						end else begin
							wp_q <= wp_q + AW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and read addressing, captured at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			in_left_q  <= in_left;
			in_right_q <= in_right;
			i0_q       <= i0_n;
			i1_q       <= i1_n;
			fr_q       <= rp_w[7:0];
			ok0_q      <= full_q || (i0_n < wp_q);
			ok1_q      <= full_q || (i1_n < wp_q);
		end
		// ping-pong cross feed of the right input
		if (state_q == S_RA0) begin
			c_q <= sdl_pkg::sat_s(sdl_pkg::rnd16(cp));
		end
	end

	sdl_lane #(.STORE_DEPTH(STORE_DEPTH)) u_lane_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_addr ((state_q == S_RA0) ? i0_q : i1_q),
		.wr_addr (wp_q),
		.in_s    (in_left_q),
		.w_in    (w_l),
		.wet_in  (wet_l),
		.fb      (fb_l),
		.res     (res_l)
	);

	sdl_lane #(.STORE_DEPTH(STORE_DEPTH)) u_lane_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_addr ((state_q == S_RA0) ? i0_q : i1_q),
		.wr_addr (wp_q),
		.in_s    (in_right_q),
		.w_in    (w_r),
		.wet_in  (wet_r),
		.fb      (fb_r),
		.res     (res_r)
	);

	sdl_merge u_merge (
		.mode  (mode_q),
		.in_l  (in_left_q),
		.in_r  (in_right_q),
		.fb_l  (fb_l),
		.fb_r  (fb_r),
		.c     (c_q),
		.w_l   (w_l),
		.w_r   (w_r),
		.wet_l (wet_l),
		.wet_r (wet_r)
	);

	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;

	// once the pointer has wrapped every entry stays written
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("fill flag dropped");

	// the second read neighbor follows the first, wrapping at the end
	a_neighbor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |->
		((i1_q == i0_q + AW'(1)) || ((i0_q == AW'(STORE_DEPTH - 1)) && (i1_q == '0))))
		else $error("read neighbors out of step");

	// finishing an item always presents its result and frees the input
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("finished item not presented");

endmodule

// ===== tb/tb_stereo_feedback_delay.sv =====
// tb_stereo_feedback_delay: self-checking bench for the stereo feedback delay
// predicts each output pair from its own model of the stores, modes and mix;
// depends on sdl_pkg and stereo_feedback_delay
`timescale 1ns / 100ps

module tb_stereo_feedback_delay;

	localparam int DEPTH = 65536;
	localparam int IDLE_PCT = 19;
	localparam int STUCK_LIMIT = 4000;
	// register byte addresses
	localparam logic [4:0] REG_MODE = 5'd0;
	localparam logic [4:0] REG_DELAY = 5'd4;
	localparam logic [4:0] REG_FEEDBACK = 5'd8;
	localparam logic [4:0] REG_DEPTH = 5'd12;
	localparam logic [4:0] REG_MIX = 5'd16;
	localparam logic [4:0] REG_FLOOR = 5'd20;
	localparam longint SPOS = (longint'(1) << 23) - 1;
	localparam longint SNEG = -(longint'(1) << 23);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sdl_pkg::sample_t in_left = '0;
	sdl_pkg::sample_t in_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sdl_pkg::sample_t out_left;
	sdl_pkg::sample_t out_right;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	stereo_feedback_delay dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_left(in_left), .in_right(in_right),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_left(out_left), .out_right(out_right),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// model state: echo stores, write pointer, tape smoothers, tanh curve
	longint echo_l [DEPTH];
	longint echo_r [DEPTH];
	int unsigned wr_ptr;
	longint smooth_l, smooth_r;
	longint curve [0:256];

	// model copy of the registers
	sdl_pkg::mode_t cur_mode;
	longint unsigned cur_delay, cur_fb, cur_depth, cur_mix, cur_floor;

	sdl_pkg::sample_t want_left_q[$];
	sdl_pkg::sample_t want_right_q[$];
	int err_count = 0;
	bit calm = 1'b0;	// no idling on either side while set
	int stuck = 0;

	function automatic longint clip(input longint v);
		if (v > SPOS) return SPOS;
		if (v < SNEG) return SNEG;
		return v;
	endfunction

	function automatic longint round16(input longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint unsigned unity_cap(input longint unsigned v);
		return (v > 65536) ? 65536 : v;
	endfunction

	// tanh(4k/256) as 1 - 2/(e^(8k/256)+1), exponent from whole powers and a series
	task automatic make_curve();
		longint unsigned exp_q16 [0:8];
		longint unsigned y8, whole, f, term, sum, e24, den, num;
		exp_q16 = '{65536, 178145, 484249, 1316326, 3578144,
			9726405, 26439109, 71868951, 195360063};
		for (int k = 0; k <= 256; k++) begin
			y8 = k * 8;
			whole = y8 / 256;
			f = ((y8 % 256) << 32) / 256;
			term = 64'd1 << 32;
			sum = term;
			for (int n = 1; n <= 24; n++) begin
				term = ((term * f) >> 32) / n;
				sum += term;
			end
			if (whole > 8) whole = 8;
			e24 = ((sum >> 8) * exp_q16[whole]) >> 16;
			den = e24 + (64'd1 << 24);
			num = 64'd1 << 48;
			curve[k] = (longint'(1) << 23) - longint'((num + den / 2) / den);
		end
	endtask

	function automatic longint tap_read(ref longint store [DEPTH]);
		longint unsigned d, rp;
		int unsigned i0, i1;
		longint fr;
		d = cur_delay;
		if (d < 256) d = 256;
		if (d > (DEPTH - 2) * 256) d = (DEPTH - 2) * 256;
		rp = ((longint'(wr_ptr) + DEPTH) << 8) - d;
		while (rp >= DEPTH * 256) rp -= DEPTH * 256;
		i0 = rp >> 8;
		i1 = (i0 + 1) % DEPTH;
		fr = rp & 255;
		return (store[i0] * (256 - fr) + store[i1] * fr + 128) >>> 8;
	endfunction

	// one-pole smoother then table saturator with drive 1 + 2*depth
	function automatic longint tape_shape(input longint w, inout longint s);
		longint unsigned g, a, pos, idx;
		longint r, frac;
		g = 65536 + 2 * unity_cap(cur_depth);
		s = clip(s + round16((w - s) * 13107));
		a = longint'(s < 0 ? -s : s) * g;
		pos = (a * 256) >> 25;
		idx = pos >> 16;
		if (idx >= 256) begin
			r = curve[256];
		end else begin
			frac = pos & 16'hFFFF;
			r = curve[idx] + round16((curve[idx + 1] - curve[idx]) * frac);
		end
		return clip(s < 0 ? -r : r);
	endfunction

	// advance the model by one pair and queue the expected output
	task automatic predict_pair(input sdl_pkg::sample_t l_in, input sdl_pkg::sample_t r_in);
		longint il, ir, fbl, fbr, wetl, wetr, wl, wr, c, avg, dry, wet, fg, mix;
		il = l_in;
		ir = r_in;
		fg = unity_cap(cur_fb);
		mix = unity_cap(cur_mix);
		fbl = tap_read(echo_l);
		fbr = tap_read(echo_r);
		wetl = fbl;
		wetr = fbr;
		case (cur_mode)
			sdl_pkg::MODE_PING: begin
				// right input cross-fed with width set by depth
				c = clip(round16(ir * (65536 - longint'(unity_cap(cur_depth)))));
				wl = clip(clip(il + c) + fbr);
				wr = clip(c + fbl);
			end
			sdl_pkg::MODE_MONO: begin
				avg = (fbl + fbr) >>> 1;
				wl = clip(((il + ir) >>> 1) + avg);
				wr = wl;
				wetl = avg;
				wetr = avg;
			end
			default: begin
				wl = clip(il + fbl);
				wr = clip(ir + fbr);
			end
		endcase
		if (cur_mode == sdl_pkg::MODE_TAPE) begin
			wl = tape_shape(wl, smooth_l);
			wr = tape_shape(wr, smooth_r);
		end
		echo_l[wr_ptr] = clip(round16(wl * fg));
		echo_r[wr_ptr] = clip(round16(wr * fg));
		wr_ptr = (wr_ptr + 1) % DEPTH;
		if (mix <= longint'(cur_floor)) begin
			want_left_q.push_back(l_in);
			want_right_q.push_back(r_in);
		end else begin
			dry = 2 * (65536 - mix);
			wet = 2 * mix;
			if (dry > 65536) dry = 65536;
			if (wet > 65536) wet = 65536;
			want_left_q.push_back(sdl_pkg::sample_t'(clip(round16(il * dry + wetl * wet))));
			want_right_q.push_back(sdl_pkg::sample_t'(clip(round16(ir * dry + wetr * wet))));
		end
	endtask

	// offer one item, hold it until accepted, then update the model
	task automatic send_pair(input sdl_pkg::sample_t l_in, input sdl_pkg::sample_t r_in);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_left <= l_in;
		in_right <= r_in;
		do @(posedge clk); while (in_stall);
		predict_pair(l_in, r_in);
	endtask

	// stop offering and let every expected pair come out, plus the pipeline depth
	task automatic drain();
		in_valid <= 1'b0;
		while (want_left_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// register write in a setup and an access phase, only while the block is idle
	task automatic reg_write(input logic [4:0] addr, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_MODE: cur_mode = sdl_pkg::mode_t'(val[1:0]);
			REG_DELAY: cur_delay = val[23:0];
			REG_FEEDBACK: cur_fb = val[16:0];
			REG_DEPTH: cur_depth = val[16:0];
			REG_MIX: cur_mix = val[16:0];
			REG_FLOOR: cur_floor = val[16:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_all(input sdl_pkg::mode_t m, input logic [31:0] dly,
			input logic [31:0] fb, input logic [31:0] dep, input logic [31:0] mx,
			input logic [31:0] flr);
		drain();
		reg_write(REG_MODE, 32'(m));
		reg_write(REG_DELAY, dly);
		reg_write(REG_FEEDBACK, fb);
		reg_write(REG_DEPTH, dep);
		reg_write(REG_MIX, mx);
		reg_write(REG_FLOOR, flr);
	endtask

	function automatic sdl_pkg::sample_t any_sample();
		case ($urandom_range(7))
			0: return sdl_pkg::sample_t'(SPOS);
			1: return sdl_pkg::sample_t'(SNEG);
			2: return sdl_pkg::sample_t'(int'($urandom_range(255)) - 128);
			default: return sdl_pkg::sample_t'($urandom);
		endcase
	endfunction

	// reset values: mix at the floor, so the dry input passes
	task automatic test_after_reset();
		send_pair(sdl_pkg::sample_t'(SPOS), sdl_pkg::sample_t'(SNEG));
		send_pair('0, '1);
		send_pair(sdl_pkg::sample_t'(SNEG), sdl_pkg::sample_t'(SPOS));
	endtask

	// each mode with the sample extremes, short delay so the echo comes back
	task automatic test_modes_directed();
		for (int m = 0; m < 4; m++) begin
			set_all(sdl_pkg::mode_t'(m), 32'd384, 32'd65536, 32'd32768, 32'd40000, 32'd0);
			send_pair(sdl_pkg::sample_t'(SPOS), sdl_pkg::sample_t'(SPOS));
			send_pair(sdl_pkg::sample_t'(SNEG), sdl_pkg::sample_t'(SNEG));
			send_pair(sdl_pkg::sample_t'(SPOS), sdl_pkg::sample_t'(SNEG));
			send_pair('0, '0);
		end
	endtask

	// gains above one clamp, delay below one sample and beyond the store clamp
	task automatic test_clamps();
		set_all(sdl_pkg::MODE_TAPE, 32'd0, 32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 32'd0);
		send_pair(sdl_pkg::sample_t'(SPOS), sdl_pkg::sample_t'(SNEG));
		send_pair(sdl_pkg::sample_t'(SNEG), sdl_pkg::sample_t'(SPOS));
		set_all(sdl_pkg::MODE_STEREO, 32'hFFFFFF, 32'd65536, 32'd0, 32'd65536, 32'h1FFFF);
		send_pair(sdl_pkg::sample_t'(SPOS), sdl_pkg::sample_t'(SNEG));
		set_all(sdl_pkg::MODE_PING, 32'd16776704, 32'd65536, 32'd65536, 32'd65536,
			32'd65535);
		send_pair(sdl_pkg::sample_t'(SPOS), sdl_pkg::sample_t'(SPOS));
	endtask

	// random settings per block, every mode, extremes mixed in
	task automatic test_random(input int blocks, input int per_block);
		logic [31:0] dly, fb, dep, mx, flr;
		for (int b = 0; b < blocks; b++) begin
			case ($urandom_range(9))
				0: dly = 32'hFFFFFF;
				1: dly = $urandom_range(255);
				2: dly = $urandom_range(16776704, 256);
				default: dly = $urandom_range(40 * 256, 256);
			endcase
			fb = ($urandom_range(4) == 0) ? 32'(65536 * $urandom_range(1)) :
				32'($urandom_range(131071));
			dep = ($urandom_range(3) == 0) ? 32'h1FFFF : 32'($urandom_range(65536));
			mx = ($urandom_range(4) == 0) ? 32'(65536 * $urandom_range(2)) :
				32'($urandom_range(65536));
			flr = ($urandom_range(2) == 0) ? 32'($urandom_range(131071)) : 32'd0;
			set_all(sdl_pkg::mode_t'(b % 4), dly, fb, dep, mx, flr);
			calm = (b == 3);
			for (int i = 0; i < per_block; i++) send_pair(any_sample(), any_sample());
			calm = 1'b0;
		end
	endtask

	initial begin
		cur_mode = sdl_pkg::MODE_STEREO;
		cur_delay = 256;
		cur_fb = 0;
		cur_depth = 0;
		cur_mix = 0;
		cur_floor = 0;
		wr_ptr = 0;
		smooth_l = 0;
		smooth_r = 0;
		foreach (echo_l[i]) begin
			echo_l[i] = 0;
			echo_r[i] = 0;
		end
		make_curve();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_modes_directed();
		test_clamps();
		test_random(16, 64);
		drain();
		if (err_count == 0) begin
			$display("tb_stereo_feedback_delay: clean");
		end else begin
			$display("tb_stereo_feedback_delay: errors");
		end
		$finish;
	end

	// output side stalls at random, except during the calm block
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// compare each accepted pair with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (want_left_q.size() == 0) begin
				$error("unexpected item: out_left %0d out_right %0d", out_left, out_right);
				err_count++;
			end else begin
				if (out_left !== want_left_q[0]) begin
					$error("out_left expected %0d got %0d", want_left_q[0], out_left);
					err_count++;
				end
				if (out_right !== want_right_q[0]) begin
					$error("out_right expected %0d got %0d", want_right_q[0], out_right);
					err_count++;
				end
				void'(want_left_q.pop_front());
				void'(want_right_q.pop_front());
			end
		end
	end

	// watchdog: too long with no item moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck <= 0;
		end else begin
			stuck <= stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("tb_stereo_feedback_delay: errors");
				$finish;
			end
		end
	end

endmodule
